>>> rtl/core/tvng_pkg.sv
// ----------------------------------------------------------------------------
// Torus vertex and normal generator: shared definitions
// Field widths, register indices, CORDIC constants and the structs passed
// between the rotation cells and the shading back end.
// ----------------------------------------------------------------------------
package tvng_pkg;

    localparam int IDX_W        = 9;
    localparam int CFG_W        = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int POS_W        = 32;
    localparam int NORM_W       = 16;
    localparam int PHASE_W      = 32;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_ITERS = 20;
    localparam int WIDE_W       = 48;

    localparam int DEFAULT_ANGLE_BITS = 16;
    localparam int DEFAULT_SEG_MAX    = 256;

    localparam logic [CFG_W-1:0] RST_MAJOR_RADIUS       = 16'd4096;
    localparam logic [CFG_W-1:0] RST_MINOR_RADIUS       = 16'd1024;
    localparam logic [CFG_W-1:0] RST_MAJOR_ANGLE_STEP   = 16'd4096;
    localparam logic [CFG_W-1:0] RST_MINOR_ANGLE_STEP   = 16'd4096;
    localparam logic [CFG_W-1:0] RST_NORMAL_LINE_LENGTH = 16'd1573;

    // CORDIC gain in Q2.30, used as the starting x value.
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in units of 2^-32 of a full turn.
    localparam logic [PHASE_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10680862,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
        32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303
    };

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAJOR_RADIUS       = 3'd0,
        REG_MINOR_RADIUS       = 3'd1,
        REG_MAJOR_ANGLE_STEP   = 3'd2,
        REG_MINOR_ANGLE_STEP   = 3'd3,
        REG_NORMAL_LINE_LENGTH = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [PHASE_W-1:0]  z;
        logic [1:0]                 quad;
    } rot_t;

    typedef struct packed {
        rot_t theta;
        rot_t phi;
    } rot_pair_t;

    typedef struct packed {
        logic [CFG_W-1:0] major_radius;
        logic [CFG_W-1:0] minor_radius;
        logic [CFG_W-1:0] normal_line_length;
    } shape_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic signed [POS_W-1:0]  tip_x;
        logic signed [POS_W-1:0]  tip_y;
        logic signed [POS_W-1:0]  tip_z;
    } vertex_t;

endpackage

>>> rtl/core/tvng_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation for both the major and the minor angle, with a
// register stage and its own valid/ready handshake.
// ----------------------------------------------------------------------------
module tvng_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tvng_pkg::rot_pair_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tvng_pkg::rot_pair_t out_data
);
    import tvng_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rot_pair_t data_reg;
    rot_pair_t data_next;

    function automatic rot_t rotate(input rot_t r);
        rot_t                       o;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic signed [PHASE_W-1:0]  a;
        xs     = r.x >>> ITER;
        ys     = r.y >>> ITER;
        a      = $signed(ATAN_TURN[ITER]);
        o.quad = r.quad;
        if (!r.z[PHASE_W-1]) begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - a;
        end else begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + a;
        end
        return o;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next      = in_ready ? in_valid : valid_reg;
        data_next.theta = rotate(in_data.theta);
        data_next.phi   = rotate(in_data.phi);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/tvng_shade.sv
// ----------------------------------------------------------------------------
// Torus shading back end
// Applies the quadrant to the rotated vectors, rounds them to Q1.15 and
// forms the vertex, the normal and the normal line tip over four stages.
// ----------------------------------------------------------------------------
module tvng_shade (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tvng_pkg::shape_cfg_t cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tvng_pkg::rot_pair_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tvng_pkg::vertex_t    out_data
);
    import tvng_pkg::*;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] c;
        logic signed [NORM_W-1:0] s;
    } trig_t;

    // Stage valids and readies
    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] rdy;

    // Stage 0: Q1.15 sine and cosine
    trig_t theta_reg, theta_next;
    trig_t phi_reg, phi_next;

    // Stage 1: first products
    logic signed [33:0]       ring_reg, ring_next;
    logic signed [32:0]       rsp_reg, rsp_next;
    logic signed [31:0]       ctcp_reg, ctcp_next;
    logic signed [31:0]       stcp_reg, stcp_next;
    logic signed [NORM_W-1:0] ct1_reg, st1_reg, sp1_reg;

    // Stage 2: vertex and normal
    vertex_t vtx_reg, vtx_next;

    // Stage 3: adds the tip
    vertex_t out_reg, out_next;

    function automatic logic signed [WIDE_W-1:0] rshift(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              sh
    );
        return (v + (48'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [NORM_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [NORM_W-1:0] r;
        if (v > 48'sd32767) begin
            r = 16'sd32767;
        end else if (v < -48'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[NORM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic trig_t unfold(input rot_t r);
        logic signed [CORDIC_W-1:0] c;
        logic signed [CORDIC_W-1:0] s;
        trig_t                      t;
        case (quad_t'(r.quad))
            QUAD_I: begin
                c = r.x;
                s = r.y;
            end
            QUAD_II: begin
                c = -r.y;
                s = r.x;
            end
            QUAD_III: begin
                c = -r.x;
                s = -r.y;
            end
            default: begin
                c = r.y;
                s = -r.x;
            end
        endcase
        t.c = sat16(rshift(WIDE_W'(c), 15));
        t.s = sat16(rshift(WIDE_W'(s), 15));
        return t;
    endfunction

    // A stage may take a new beat when it is empty or its successor takes its beat.
    always_comb begin
        rdy[3] = !valid_reg[3] || out_ready;
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];
        rdy[0] = !valid_reg[0] || rdy[1];
        valid_next[0] = rdy[0] ? in_valid     : valid_reg[0];
        valid_next[1] = rdy[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];
    end

    always_comb begin
        theta_next = unfold(in_data.theta);
        phi_next   = unfold(in_data.phi);

        // Ring radius R + r*cos(phi) with 15 fraction bits.
        ring_next = $signed({3'b000, cfg.major_radius, 15'b0})
                  + $signed({18'b0, cfg.minor_radius}) * 34'(phi_reg.c);
        rsp_next  = $signed({17'b0, cfg.minor_radius}) * 33'(phi_reg.s);
        ctcp_next = 32'(theta_reg.c) * 32'(phi_reg.c);
        stcp_next = 32'(theta_reg.s) * 32'(phi_reg.c);

        vtx_next        = '0;
        vtx_next.pos_x  = sat32(rshift(WIDE_W'(ring_reg) * WIDE_W'(ct1_reg), 26));
        vtx_next.pos_y  = sat32(rshift(WIDE_W'(ring_reg) * WIDE_W'(st1_reg), 26));
        vtx_next.pos_z  = sat32(rshift(WIDE_W'(rsp_reg), 11));
        vtx_next.norm_x = sat16(rshift(WIDE_W'(ctcp_reg), 15));
        vtx_next.norm_y = sat16(rshift(WIDE_W'(stcp_reg), 15));
        vtx_next.norm_z = sp1_reg;

        out_next       = vtx_reg;
        out_next.tip_x = sat32(WIDE_W'(vtx_reg.pos_x) + rshift(WIDE_W'(vtx_reg.norm_x)
                       * $signed({32'b0, cfg.normal_line_length}), 15));
        out_next.tip_y = sat32(WIDE_W'(vtx_reg.pos_y) + rshift(WIDE_W'(vtx_reg.norm_y)
                       * $signed({32'b0, cfg.normal_line_length}), 15));
        out_next.tip_z = sat32(WIDE_W'(vtx_reg.pos_z) + rshift(WIDE_W'(vtx_reg.norm_z)
                       * $signed({32'b0, cfg.normal_line_length}), 15));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            theta_reg <= theta_next;
            phi_reg   <= phi_next;
        end
        if (rdy[1] && valid_reg[0]) begin
            ring_reg <= ring_next;
            rsp_reg  <= rsp_next;
            ctcp_reg <= ctcp_next;
            stcp_reg <= stcp_next;
            ct1_reg  <= theta_reg.c;
            st1_reg  <= theta_reg.s;
            sp1_reg  <= phi_reg.s;
        end
        if (rdy[2] && valid_reg[1]) begin
            vtx_reg <= vtx_next;
        end
        if (rdy[3] && valid_reg[2]) begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[3];
    assign out_data  = out_reg;

endmodule

>>> rtl/core/torus_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// Torus vertex and normal generator
// Turns a grid point (major index, minor index) into the torus vertex, its
// unit normal and the end of a short line along the normal.
//
//   Channel   Direction  Handshake          Payload
//   cfg       in         cfg_wr_en          cfg_index, cfg_wr_data
//   s_        in         s_valid/s_ready    s_major_index, s_minor_index
//   m_        out        m_valid/m_ready    m_pos_*, m_norm_*, m_tip_*
//
// One beat is taken per cycle while s_ready is high. A beat passes 25 registers
// (one phase stage, twenty CORDIC cells and four shading stages) before its
// result is presented.
// Every stage has its own valid bit, so empty stages keep filling while the
// output waits; s_ready falls only when every stage holds a beat.
// Reset is synchronous and active low; it empties the pipeline and loads the
// default shape.
// ----------------------------------------------------------------------------
module torus_vertex_normal_generator #(
    parameter int ANGLE_BITS = tvng_pkg::DEFAULT_ANGLE_BITS,
    parameter int SEG_MAX    = tvng_pkg::DEFAULT_SEG_MAX
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [tvng_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [tvng_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tvng_pkg::IDX_W-1:0]            s_major_index,
    input  logic [tvng_pkg::IDX_W-1:0]            s_minor_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tvng_pkg::POS_W-1:0]     m_pos_x,
    output logic signed [tvng_pkg::POS_W-1:0]     m_pos_y,
    output logic signed [tvng_pkg::POS_W-1:0]     m_pos_z,
    output logic signed [tvng_pkg::NORM_W-1:0]    m_norm_x,
    output logic signed [tvng_pkg::NORM_W-1:0]    m_norm_y,
    output logic signed [tvng_pkg::NORM_W-1:0]    m_norm_z,
    output logic signed [tvng_pkg::POS_W-1:0]     m_tip_x,
    output logic signed [tvng_pkg::POS_W-1:0]     m_tip_y,
    output logic signed [tvng_pkg::POS_W-1:0]     m_tip_z
);
    import tvng_pkg::*;

    // Only the top ANGLE_BITS bits of the phase reach the CORDIC.
    localparam logic [PHASE_W-1:0] PHASE_KEEP =
        ~((32'd1 << (PHASE_W - ANGLE_BITS)) - 32'd1);

    logic [CFG_W-1:0] major_radius_reg;
    logic [CFG_W-1:0] minor_radius_reg;
    logic [CFG_W-1:0] major_angle_step_reg;
    logic [CFG_W-1:0] minor_angle_step_reg;
    logic [CFG_W-1:0] normal_line_length_reg;

    logic      front_valid_reg;
    logic      front_valid_next;
    rot_pair_t front_data_reg;
    rot_pair_t front_data_next;

    logic      chain_valid [CORDIC_ITERS+1];
    logic      chain_ready [CORDIC_ITERS+1];
    rot_pair_t chain_data  [CORDIC_ITERS+1];

    shape_cfg_t shape_cfg;
    vertex_t    vtx;

    function automatic rot_t seed(
        input logic [IDX_W-1:0] idx,
        input logic [CFG_W-1:0] step
    );
        logic [IDX_W-1:0]       ic;
        logic [IDX_W+CFG_W-1:0] prod;
        logic [PHASE_W-1:0]     ph;
        rot_t                   r;
        ic     = (int'(idx) > SEG_MAX) ? IDX_W'(SEG_MAX) : idx;
        prod   = (IDX_W+CFG_W)'(ic) * (IDX_W+CFG_W)'(step);
        ph     = {prod[CFG_W-1:0], {(PHASE_W-CFG_W){1'b0}}} & PHASE_KEEP;
        r.x    = CORDIC_GAIN;
        r.y    = '0;
        r.z    = $signed({2'b00, ph[PHASE_W-3:0]});
        r.quad = ph[PHASE_W-1:PHASE_W-2];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_radius_reg       <= RST_MAJOR_RADIUS;
            minor_radius_reg       <= RST_MINOR_RADIUS;
            major_angle_step_reg   <= RST_MAJOR_ANGLE_STEP;
            minor_angle_step_reg   <= RST_MINOR_ANGLE_STEP;
            normal_line_length_reg <= RST_NORMAL_LINE_LENGTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAJOR_RADIUS:       major_radius_reg       <= cfg_wr_data;
                REG_MINOR_RADIUS:       minor_radius_reg       <= cfg_wr_data;
                REG_MAJOR_ANGLE_STEP:   major_angle_step_reg   <= cfg_wr_data;
                REG_MINOR_ANGLE_STEP:   minor_angle_step_reg   <= cfg_wr_data;
                REG_NORMAL_LINE_LENGTH: normal_line_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Phase stage
    assign s_ready = !front_valid_reg || chain_ready[0];

    always_comb begin
        front_valid_next      = s_ready ? s_valid : front_valid_reg;
        front_data_next.theta = seed(s_major_index, major_angle_step_reg);
        front_data_next.phi   = seed(s_minor_index, minor_angle_step_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            front_data_reg <= front_data_next;
        end
    end

    assign chain_valid[0] = front_valid_reg;
    assign chain_data[0]  = front_data_reg;

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
        tvng_cordic_cell #(
            .ITER(k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (chain_valid[k]),
            .in_ready (chain_ready[k]),
            .in_data  (chain_data[k]),
            .out_valid(chain_valid[k+1]),
            .out_ready(chain_ready[k+1]),
            .out_data (chain_data[k+1])
        );
    end

    assign shape_cfg.major_radius       = major_radius_reg;
    assign shape_cfg.minor_radius       = minor_radius_reg;
    assign shape_cfg.normal_line_length = normal_line_length_reg;

    tvng_shade u_shade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (shape_cfg),
        .in_valid (chain_valid[CORDIC_ITERS]),
        .in_ready (chain_ready[CORDIC_ITERS]),
        .in_data  (chain_data[CORDIC_ITERS]),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (vtx)
    );

    assign m_pos_x  = vtx.pos_x;
    assign m_pos_y  = vtx.pos_y;
    assign m_pos_z  = vtx.pos_z;
    assign m_norm_x = vtx.norm_x;
    assign m_norm_y = vtx.norm_y;
    assign m_norm_z = vtx.norm_z;
    assign m_tip_x  = vtx.tip_x;
    assign m_tip_y  = vtx.tip_y;
    assign m_tip_z  = vtx.tip_z;

endmodule

>>> rtl/core/tvng_checker.sv
// ----------------------------------------------------------------------------
// Torus vertex and normal generator: port checker
// Watches the ports of the top level for stalls, back pressure and the
// geometric relations between vertex, normal and tip.
// ----------------------------------------------------------------------------
module tvng_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_pos_x,
    input logic signed [31:0] m_pos_y,
    input logic signed [31:0] m_pos_z,
    input logic signed [15:0] m_norm_x,
    input logic signed [15:0] m_norm_y,
    input logic signed [15:0] m_norm_z,
    input logic signed [31:0] m_tip_x,
    input logic signed [31:0] m_tip_y,
    input logic signed [31:0] m_tip_z
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid
            && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_pos_z)
            && $stable(m_norm_x) && $stable(m_norm_y) && $stable(m_norm_z)
            && $stable(m_tip_x) && $stable(m_tip_y) && $stable(m_tip_z))
        else $error("result beat changed while stalled");

    // With the output free, every stage can move, so the input is open.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked while the output can drain");

    // The tube radius is never negative, so z follows the sign of the normal.
    a_z_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_norm_z[15] && (m_pos_z[31] || m_pos_z == 32'sd0))
                 || (!m_norm_z[15] && !m_pos_z[31]))
        else $error("vertex z disagrees with normal z");

    // The tip lies on the side of the vertex that the normal points to.
    a_tip_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_norm_z[15] && m_tip_z <= m_pos_z)
                 || (!m_norm_z[15] && m_tip_z >= m_pos_z))
        else $error("tip z on the wrong side of the vertex");

endmodule

bind torus_vertex_normal_generator tvng_checker u_tvng_checker (.*);

>>> bench/tb_torus_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// Torus vertex and normal generator: self-checking bench
// Streams grid points through the block under several shapes, including the
// all-zero and all-ones extremes. An in-bench CORDIC model predicts every
// vertex, normal and tip. A scoreboard compares each result beat in order.
// Input bursts and output stalls vary throughout the run.
// ----------------------------------------------------------------------------
module tb_torus_vertex_normal_generator;

    import tvng_pkg::*;

    localparam int   ANGLE_BITS = DEFAULT_ANGLE_BITS;
    localparam int   SEG_MAX    = DEFAULT_SEG_MAX;
    localparam int   DRAIN_WAIT = 40;
    localparam int   TIMEOUT    = 2000000;
    localparam int   ITERS      = 20;
    localparam longint ROT_GAIN = 652032874;

    typedef enum logic [1:0] {
        QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH
    } quadrant_t;

    class torus_vertex_scoreboard;
        logic [CFG_W-1:0] major_radius;
        logic [CFG_W-1:0] minor_radius;
        logic [CFG_W-1:0] major_step;
        logic [CFG_W-1:0] minor_step;
        logic [CFG_W-1:0] line_length;
        longint           turn_atan [ITERS];
        vertex_t          expected_vertices [$];
        int               errors;
        int               grid_points;
        int               vertices_checked;
        int               clamped_points;

        function new();
            turn_atan = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10680862, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41721,
                          20860, 10430, 5215, 2607, 1303};
            major_radius = 16'd4096;
            minor_radius = 16'd1024;
            major_step   = 16'd4096;
            minor_step   = 16'd4096;
            line_length  = 16'd1573;
            errors = 0;
            grid_points = 0;
            vertices_checked = 0;
            clamped_points = 0;
        endfunction

        function void set_register(cfg_reg_t which, logic [CFG_W-1:0] value);
            case (which)
                REG_MAJOR_RADIUS:       major_radius = value;
                REG_MINOR_RADIUS:       minor_radius = value;
                REG_MAJOR_ANGLE_STEP:   major_step   = value;
                REG_MINOR_ANGLE_STEP:   minor_step   = value;
                REG_NORMAL_LINE_LENGTH: line_length  = value;
                default: ;
            endcase
        endfunction

        // Adds half an LSB and shifts down arithmetically, so ties go upwards.
        function longint round_half_up(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [PHASE_W-1:0] angle_phase(logic [IDX_W-1:0] idx,
                                                 logic [CFG_W-1:0] step);
            longint              turns;
            logic [PHASE_W-1:0]  phase;
            logic [PHASE_W-1:0]  keep;
            turns = longint'(idx > SEG_MAX ? SEG_MAX : idx) * longint'(step);
            phase = {turns[15:0], 16'h0000};
            keep  = ~((32'd1 << (PHASE_W - ANGLE_BITS)) - 32'd1);
            return phase & keep;
        endfunction

        function void sin_cos_q15(logic [PHASE_W-1:0] phase, output longint c,
                                  output longint s);
            longint x, y, z, xs, ys, cr, sr;
            int     i;
            x = ROT_GAIN;
            y = 0;
            z = longint'(phase[29:0]);
            for (i = 0; i < ITERS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - turn_atan[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + turn_atan[i];
                end
            end
            // The rotation only covers one quadrant; the top phase bits fold it out.
            case (quadrant_t'(phase[31:30]))
                QUAD_FIRST:  begin cr = x;  sr = y;  end
                QUAD_SECOND: begin cr = -y; sr = x;  end
                QUAD_THIRD:  begin cr = -x; sr = -y; end
                default:     begin cr = y;  sr = -x; end
            endcase
            c = clip16(round_half_up(cr, 15));
            s = clip16(round_half_up(sr, 15));
        endfunction

        function vertex_t predict_vertex(logic [IDX_W-1:0] maj, logic [IDX_W-1:0] mnr);
            longint  ct, st, cp, sp, ring, len;
            longint  p [3];
            longint  n [3];
            vertex_t v;
            sin_cos_q15(angle_phase(maj, major_step), ct, st);
            sin_cos_q15(angle_phase(mnr, minor_step), cp, sp);
            ring = (longint'(major_radius) << 15) + longint'(minor_radius) * cp;
            p[0] = clip32(round_half_up(ring * ct, 26));
            p[1] = clip32(round_half_up(ring * st, 26));
            p[2] = clip32(round_half_up(longint'(minor_radius) * sp, 11));
            n[0] = clip16(round_half_up(ct * cp, 15));
            n[1] = clip16(round_half_up(st * cp, 15));
            n[2] = sp;
            len  = longint'(line_length);
            v.pos_x  = 32'(p[0]);
            v.pos_y  = 32'(p[1]);
            v.pos_z  = 32'(p[2]);
            v.norm_x = 16'(n[0]);
            v.norm_y = 16'(n[1]);
            v.norm_z = 16'(n[2]);
            v.tip_x  = 32'(clip32(p[0] + round_half_up(n[0] * len, 15)));
            v.tip_y  = 32'(clip32(p[1] + round_half_up(n[1] * len, 15)));
            v.tip_z  = 32'(clip32(p[2] + round_half_up(n[2] * len, 15)));
            return v;
        endfunction

        function void note_grid_point(logic [IDX_W-1:0] maj, logic [IDX_W-1:0] mnr);
            vertex_t v;
            v = predict_vertex(maj, mnr);
            expected_vertices = {expected_vertices, v};
            grid_points++;
            if (maj > SEG_MAX || mnr > SEG_MAX) clamped_points++;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0) begin
                $error("result beat arrived with no grid point outstanding");
                errors++;
                return;
            end
            want = expected_vertices.pop_front();
            vertices_checked++;
            compare_field("pos_x",  want.pos_x,  got.pos_x);
            compare_field("pos_y",  want.pos_y,  got.pos_y);
            compare_field("pos_z",  want.pos_z,  got.pos_z);
            compare_field("norm_x", want.norm_x, got.norm_x);
            compare_field("norm_y", want.norm_y, got.norm_y);
            compare_field("norm_z", want.norm_z, got.norm_z);
            compare_field("tip_x",  want.tip_x,  got.tip_x);
            compare_field("tip_y",  want.tip_y,  got.tip_y);
            compare_field("tip_z",  want.tip_z,  got.tip_z);
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_W-1:0]    cfg_index;
    logic [CFG_W-1:0]         cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [IDX_W-1:0]         s_major_index;
    logic [IDX_W-1:0]         s_minor_index;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [POS_W-1:0]  m_pos_x, m_pos_y, m_pos_z;
    logic signed [NORM_W-1:0] m_norm_x, m_norm_y, m_norm_z;
    logic signed [POS_W-1:0]  m_tip_x, m_tip_y, m_tip_z;

    torus_vertex_scoreboard sb;
    int                     burst_left;
    int unsigned            stall_cycle;
    int                     shapes_used;

    torus_vertex_normal_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_major_index (s_major_index),
        .s_minor_index (s_minor_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_z       (m_pos_z),
        .m_norm_x      (m_norm_x),
        .m_norm_y      (m_norm_y),
        .m_norm_z      (m_norm_z),
        .m_tip_x       (m_tip_x),
        .m_tip_y       (m_tip_y),
        .m_tip_z       (m_tip_z)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver cycles through four moods: always ready, coin toss, ready only when the
    // counter's low two bits are zero, and long stalls that back the pipeline up to the input.
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        case (stall_cycle[10:9])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= 1'($urandom_range(0, 1));
            2'd2:    m_ready <= (stall_cycle[1:0] == 2'd0);
            default: m_ready <= (stall_cycle % 40) >= 30;
        endcase
    end

    always @(posedge aclk) begin : result_monitor
        vertex_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pos_x  = m_pos_x;
            got.pos_y  = m_pos_y;
            got.pos_z  = m_pos_z;
            got.norm_x = m_norm_x;
            got.norm_y = m_norm_y;
            got.norm_z = m_norm_z;
            got.tip_x  = m_tip_x;
            got.tip_y  = m_tip_y;
            got.tip_z  = m_tip_z;
            sb.check_vertex(got);
        end
    end

    task automatic send_grid_point(logic [IDX_W-1:0] maj, logic [IDX_W-1:0] mnr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_major_index <= maj;
        s_minor_index <= mnr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_grid_point(maj, mnr);
        burst_left--;
    endtask

    function automatic logic [IDX_W-1:0] random_index();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return IDX_W'($urandom);
        if (pick == 1) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return IDX_W'(SEG_MAX);
                2:       return IDX_W'(SEG_MAX + 1);
                default: return '1;
            endcase
        end
        return IDX_W'($urandom_range(0, SEG_MAX));
    endfunction

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= which;
        cfg_wr_data <= value;
        sb.set_register(which, value);
        @(posedge aclk);
    endtask

    // New shapes go in only once the pipeline has emptied.
    task automatic load_shape(logic [CFG_W-1:0] big_r, logic [CFG_W-1:0] tube_r,
                              logic [CFG_W-1:0] maj_step, logic [CFG_W-1:0] mnr_step,
                              logic [CFG_W-1:0] len);
        wait_idle();
        write_reg(REG_MAJOR_RADIUS, big_r);
        write_reg(REG_MINOR_RADIUS, tube_r);
        write_reg(REG_MAJOR_ANGLE_STEP, maj_step);
        write_reg(REG_MINOR_ANGLE_STEP, mnr_step);
        write_reg(REG_NORMAL_LINE_LENGTH, len);
        cfg_wr_en <= 1'b0;
        shapes_used++;
    endtask

    task automatic run_random(int count);
        int k;
        for (k = 0; k < count; k++) send_grid_point(random_index(), random_index());
        s_valid <= 1'b0;
    endtask

    initial begin
        int k;
        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_MAJOR_RADIUS;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_major_index = '0;
        s_minor_index = '0;
        m_ready       = 1'b0;
        stall_cycle   = 0;
        burst_left    = 0;
        shapes_used   = 1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset shape: origin, ends of the index range, indices beyond the
        // segment limit, quadrant boundaries and the full-turn wrap.
        send_grid_point(9'd0, 9'd0);
        send_grid_point(9'd256, 9'd256);
        send_grid_point(9'd257, 9'd0);
        send_grid_point(9'd0, 9'd257);
        send_grid_point(9'd511, 9'd511);
        send_grid_point(9'd341, 9'd170);
        send_grid_point(9'd255, 9'd1);
        send_grid_point(9'd1, 9'd255);
        send_grid_point(9'd4, 9'd4);
        send_grid_point(9'd8, 9'd8);
        send_grid_point(9'd12, 9'd12);
        send_grid_point(9'd16, 9'd16);
        send_grid_point(9'd2, 9'd6);
        send_grid_point(9'd170, 9'd85);
        send_grid_point(9'd128, 9'd64);
        send_grid_point(9'd100, 9'd200);
        s_valid <= 1'b0;

        load_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(60);
        load_shape(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(40);
        load_shape(16'd4096, 16'd4096, 16'd16384, 16'd8192, 16'd32768);
        run_random(40);
        load_shape(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'd1);
        run_random(60);
        for (k = 0; k < 5; k++) begin
            load_shape(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                       CFG_W'($urandom), CFG_W'($urandom));
            run_random(70);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Run covered %0d grid points (%0d beyond the segment limit) under %0d shapes.",
                 sb.grid_points, sb.clamped_points, shapes_used);
        $display("%0d result beats checked, %0d field errors.",
                 sb.vertices_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("Run stopped: timed out waiting for the block.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tvng_pkg.sv
rtl/core/tvng_cordic_cell.sv
rtl/core/tvng_shade.sv
rtl/core/torus_vertex_normal_generator.sv
rtl/core/tvng_checker.sv
bench/tb_torus_vertex_normal_generator.sv
